// File: src/cdsd_pkg.sv
// shared types, constants and helpers for the civil date to serial date pipeline
// no dependencies
package cdsd_pkg;

    localparam int YEAR_W   = 14;
    localparam int FIELD_W  = 7;
    localparam int MICRO_W  = 20;
    localparam int STATUS_W = 3;
    localparam int SERIAL_W = 23;
    localparam int TIME_W   = 37;
    localparam int YS_W     = 15;   // shifted year, year + 400 - march start
    localparam int LIN_W    = 24;   // linear day count before bias
    localparam int DOY_W    = 9;
    localparam int SECS_W   = 17;
    localparam int HOUR_W   = 5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_MONTH  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DAY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_HOUR   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_MINUTE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_SECOND = 3'd5;

    // floor(x / 25) = (x * DIV25_MUL) >> DIV25_SH for x below 8192
    localparam logic [12:0] DIV25_MUL = 13'd5243;
    localparam int          DIV25_SH  = 17;

    localparam logic [MICRO_W-1:0] MAX_MICRO   = 20'd999999;
    localparam logic [LIN_W-1:0]   DAY_BIAS    = 24'd839996;  // 146097 + 719468 - 25569
    localparam logic [YS_W-1:0]    YEAR_OFFSET = 15'd400;

    typedef struct packed {
        logic                bad_month;
        logic                bad_hour;
        logic                bad_minute;
        logic                bad_second;
        logic [YEAR_W-1:0]   year;
        logic [3:0]          month;
        logic [FIELD_W-1:0]  day;
        logic [YS_W-1:0]     ys;
        logic [24:0]         p_yr;    // (year / 4) * DIV25_MUL
        logic [24:0]         p_y4;    // (ys / 4) * DIV25_MUL
        logic [22:0]         p_y16;   // (ys / 16) * DIV25_MUL
        logic [SECS_W-1:0]   secs;
        logic [MICRO_W-1:0]  micro;
    } t_s1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LIN_W-1:0]    lin;
        logic [DOY_W-1:0]    doy;     // days into march-based year before the month, plus day of month minus one
        logic [TIME_W-1:0]   t_prod;
        logic [MICRO_W-1:0]  micro;
    } t_s2;

    // days from march 1 to the start of each march-based month
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
        logic [DOY_W-1:0] v;
        unique case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/civil_datetime_to_serial_date_unit.sv
// top level: civil date and time fields to serial day and time of day in microseconds
// depends on cdsd_pkg, cdsd_check, cdsd_calc, cdsd_out
//
// channel  direction  handshake           payload
// -------  ---------  ------------------  -----------------------------------------------
// in       to block   i_valid / o_stall   year month day hour twelve_hour_clock
//                                         after_noon minute second microsecond
// out      from block o_valid / i_stall   status serial_day time_of_day_us
//
// three register stages, check, calc and out; an item's result shows from the out stage register
// one transfer per cycle sustained while i_stall is low, set by the three-stage pipeline with no shared unit
// synchronous active-low reset clears the stage valid bits only
// a stage moves when it is empty or the next one moves, so bubbles are squeezed out
// o_stall rises only when all three stages hold items and the output is stalled
module civil_datetime_to_serial_date_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [cdsd_pkg::YEAR_W-1:0]          i_year,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_month,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_day,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_hour,
    input  logic                                 i_twelve_hour_clock,
    input  logic                                 i_after_noon,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_minute,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_second,
    input  logic [cdsd_pkg::MICRO_W-1:0]         i_microsecond,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [cdsd_pkg::STATUS_W-1:0]        o_status,
    output logic signed [cdsd_pkg::SERIAL_W-1:0] o_serial_day,
    output logic [cdsd_pkg::TIME_W-1:0]          o_time_of_day_us
);
    import cdsd_pkg::*;

    logic v1;
    logic v2;
    logic v3;
    logic en1;
    logic en2;
    logic en3;
    t_s1  s1;
    t_s2  s2;

    // stage advance chain, output end first
    assign en3     = !v3 || !i_stall;
    assign en2     = !v2 || en3;
    assign en1     = !v1 || en2;
    assign o_stall = !en1;
    assign o_valid = v3;

    // range checks, hour fixup, reciprocal products for the year divisions
    cdsd_check u_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (en1),
        .i_valid             (i_valid),
        .i_year              (i_year),
        .i_month             (i_month),
        .i_day               (i_day),
        .i_hour              (i_hour),
        .i_twelve_hour_clock (i_twelve_hour_clock),
        .i_after_noon        (i_after_noon),
        .i_minute            (i_minute),
        .i_second            (i_second),
        .i_microsecond       (i_microsecond),
        .o_valid             (v1),
        .o_data              (s1)
    );

    // leap rule, month length, status priority, linear day count, seconds to microseconds
    cdsd_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (v1),
        .i_data  (s1),
        .o_valid (v2),
        .o_data  (s2)
    );

    // epoch bias, fraction add, error zeroing; doubles as the output register
    cdsd_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en3),
        .i_valid          (v2),
        .i_data           (s2),
        .o_valid          (v3),
        .o_status         (o_status),
        .o_serial_day     (o_serial_day),
        .o_time_of_day_us (o_time_of_day_us)
    );

endmodule

// File: src/cdsd_check.sv
// first stage: field range checks, hour fixup, time of day seconds, divider products
// depends on cdsd_pkg
module cdsd_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [cdsd_pkg::YEAR_W-1:0]    i_year,
    input  logic [cdsd_pkg::FIELD_W-1:0]   i_month,
    input  logic [cdsd_pkg::FIELD_W-1:0]   i_day,
    input  logic [cdsd_pkg::FIELD_W-1:0]   i_hour,
    input  logic                           i_twelve_hour_clock,
    input  logic                           i_after_noon,
    input  logic [cdsd_pkg::FIELD_W-1:0]   i_minute,
    input  logic [cdsd_pkg::FIELD_W-1:0]   i_second,
    input  logic [cdsd_pkg::MICRO_W-1:0]   i_microsecond,
    output logic                           o_valid,
    output cdsd_pkg::t_s1                  o_data
);
    import cdsd_pkg::*;

    logic              r_valid;
    t_s1               r_data;
    t_s1               n_data;
    logic [HOUR_W-1:0] h12;
    logic [HOUR_W-1:0] h24;
    logic              early;   // january or february count with the prior year

    always_comb begin
        early = (i_month <= 7'd2);

        if (i_hour == 7'd12) begin
            h12 = '0;
        end else begin
            h12 = i_hour[HOUR_W-1:0];
        end
        if (i_after_noon) begin
            h12 = h12 + 5'd12;
        end

        n_data.bad_month  = (i_month == 7'd0) || (i_month > 7'd12);
        if (i_twelve_hour_clock) begin
            n_data.bad_hour = (i_hour == 7'd0) || (i_hour > 7'd12);
            h24             = h12;
        end else begin
            n_data.bad_hour = (i_hour > 7'd23);
            h24             = i_hour[HOUR_W-1:0];
        end
        n_data.bad_minute = (i_minute > 7'd59);
        n_data.bad_second = (i_second > 7'd59);

        n_data.year  = i_year;
        n_data.month = i_month[3:0];
        n_data.day   = i_day;
        n_data.ys    = {1'b0, i_year} + YEAR_OFFSET - {14'd0, early};

        n_data.p_yr  = {13'd0, i_year[YEAR_W-1:2]} * {12'd0, DIV25_MUL};
        n_data.p_y4  = {12'd0, n_data.ys[YS_W-1:2]} * {12'd0, DIV25_MUL};
        n_data.p_y16 = {12'd0, n_data.ys[YS_W-1:4]} * {10'd0, DIV25_MUL};

        n_data.secs = {12'd0, h24} * 17'd3600
                    + {11'd0, i_minute[5:0]} * 17'd60
                    + {11'd0, i_second[5:0]};
        n_data.micro = (i_microsecond > MAX_MICRO) ? MAX_MICRO : i_microsecond;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/cdsd_calc.sv
// second stage: leap year and day check, status priority, linear day count, time product
// depends on cdsd_pkg
module cdsd_calc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cdsd_pkg::t_s1   i_data,
    output logic            o_valid,
    output cdsd_pkg::t_s2   o_data
);
    import cdsd_pkg::*;

    logic              r_valid;
    t_s2               r_data;
    t_s2               n_data;
    logic [7:0]        q100;
    logic [YEAR_W-1:0] rem100;
    logic              leap;
    logic [4:0]        mlen;
    logic              bad_day;
    logic [3:0]        mp;

    always_comb begin
        q100   = i_data.p_yr[DIV25_SH+7:DIV25_SH];
        rem100 = i_data.year - {6'd0, q100} * 14'd100;
        leap   = (i_data.year[1:0] == 2'd0) && ((rem100 != '0) || (q100[1:0] == 2'd0));

        unique case (i_data.month)
            4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
            4'd2:                    mlen = leap ? 5'd29 : 5'd28;
            default:                 mlen = 5'd31;
        endcase
        bad_day = (i_data.day == 7'd0) || (i_data.day > {2'd0, mlen});

        priority if (i_data.bad_month) begin
            n_data.status = ST_BAD_MONTH;
        end else if (bad_day) begin
            n_data.status = ST_BAD_DAY;
        end else if (i_data.bad_hour) begin
            n_data.status = ST_BAD_HOUR;
        end else if (i_data.bad_minute) begin
            n_data.status = ST_BAD_MINUTE;
        end else if (i_data.bad_second) begin
            n_data.status = ST_BAD_SECOND;
        end else begin
            n_data.status = ST_OK;
        end

        // 365*y + y/4 - y/100 + y/400 on the offset year
        n_data.lin = {9'd0, i_data.ys} * 24'd365
                   + {11'd0, i_data.ys[YS_W-1:2]}
                   - {16'd0, i_data.p_y4[DIV25_SH+7:DIV25_SH]}
                   + {18'd0, i_data.p_y16[DIV25_SH+5:DIV25_SH]};

        mp         = (i_data.month > 4'd2) ? i_data.month - 4'd3 : i_data.month + 4'd9;
        n_data.doy = month_start(mp) + {2'd0, i_data.day} - 9'd1;

        n_data.t_prod = {20'd0, i_data.secs} * 37'd1000000;
        n_data.micro  = i_data.micro;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/cdsd_out.sv
// third stage: final day sum with epoch bias, time of day sum, zeroing on error
// depends on cdsd_pkg
module cdsd_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  cdsd_pkg::t_s2                   i_data,
    output logic                            o_valid,
    output logic [cdsd_pkg::STATUS_W-1:0]   o_status,
    output logic signed [cdsd_pkg::SERIAL_W-1:0] o_serial_day,
    output logic [cdsd_pkg::TIME_W-1:0]     o_time_of_day_us
);
    import cdsd_pkg::*;

    logic                       r_valid;
    logic [STATUS_W-1:0]        r_status;
    logic signed [SERIAL_W-1:0] r_serial;
    logic [TIME_W-1:0]          r_time;
    logic [LIN_W-1:0]           days;
    logic [TIME_W-1:0]          tod;

    always_comb begin
        days = i_data.lin + {15'd0, i_data.doy} - DAY_BIAS;
        tod  = i_data.t_prod + {17'd0, i_data.micro};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_status <= i_data.status;
            if (i_data.status == ST_OK) begin
                r_serial <= signed'(days[SERIAL_W-1:0]);
                r_time   <= tod;
            end else begin
                r_serial <= '0;
                r_time   <= '0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_serial_day     = r_serial;
    assign o_time_of_day_us = r_time;

endmodule

// File: tb/sv/cdsd_serial_checker.sv
// checker for the civil date to serial date unit: watches both channels, predicts each
// result from the accepted datetime fields and compares results in transfer order
// depends on cdsd_pkg for field widths and status codes
module cdsd_serial_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    input  logic                                 i_req_stall,
    input  logic [cdsd_pkg::YEAR_W-1:0]          i_year,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_month,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_day,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_hour,
    input  logic                                 i_twelve_hour_clock,
    input  logic                                 i_after_noon,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_minute,
    input  logic [cdsd_pkg::FIELD_W-1:0]         i_second,
    input  logic [cdsd_pkg::MICRO_W-1:0]         i_microsecond,
    input  logic                                 i_rsp_valid,
    input  logic                                 i_rsp_stall,
    input  logic [cdsd_pkg::STATUS_W-1:0]        i_status,
    input  logic signed [cdsd_pkg::SERIAL_W-1:0] i_serial_day,
    input  logic [cdsd_pkg::TIME_W-1:0]          i_time_of_day_us,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cdsd_pkg::*;

    localparam longint DAYS_PER_ERA  = 146097;
    localparam longint EPOCH_SHIFT   = 719468;
    localparam longint SERIAL_OFFSET = 25569;
    localparam longint US_PER_SECOND = 1000000;
    localparam longint MICRO_CEIL    = 999999;

    typedef struct {
        logic [STATUS_W-1:0]        status;
        logic signed [SERIAL_W-1:0] serial_day;
        logic [TIME_W-1:0]          time_us;
    } serial_result_t;

    serial_result_t expected_serials[$];
    serial_result_t want;

    function automatic int days_in_month(input longint yr, input longint mo);
        bit leap;
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
            return 30;
        if (mo == 2)
            return leap ? 29 : 28;
        return 31;
    endfunction

    function automatic serial_result_t serial_of_datetime(
        input logic [YEAR_W-1:0]  year,
        input logic [FIELD_W-1:0] month,
        input logic [FIELD_W-1:0] day,
        input logic [FIELD_W-1:0] hour,
        input logic               twelve,
        input logic               pm,
        input logic [FIELD_W-1:0] minute,
        input logic [FIELD_W-1:0] second,
        input logic [MICRO_W-1:0] micro
    );
        serial_result_t r;
        longint yr, mo, dy, hr, mn, sc, mu;
        longint y, era, yoe, mp, doy, doe, days, us;
        yr = year;
        mo = month;
        dy = day;
        hr = hour;
        mn = minute;
        sc = second;
        mu = micro;
        r.status     = ST_OK;
        r.serial_day = '0;
        r.time_us    = '0;

        // first failing field wins
        if (mo < 1 || mo > 12)
            r.status = ST_BAD_MONTH;
        else if (dy < 1 || dy > days_in_month(yr, mo))
            r.status = ST_BAD_DAY;
        else if (twelve ? (hr < 1 || hr > 12) : (hr > 23))
            r.status = ST_BAD_HOUR;
        else if (mn > 59)
            r.status = ST_BAD_MINUTE;
        else if (sc > 59)
            r.status = ST_BAD_SECOND;
        if (r.status != ST_OK)
            return r;

        if (twelve) begin
            if (hr == 12)
                hr = 0;
            if (pm)
                hr += 12;
        end
        if (mu > MICRO_CEIL)
            mu = MICRO_CEIL;

        // march-based year, eras of 400 years
        y    = (mo <= 2) ? yr - 1 : yr;
        era  = ((y >= 0) ? y : y - 399) / 400;
        yoe  = y - era * 400;
        mp   = (mo > 2) ? mo - 3 : mo + 9;
        doy  = (153 * mp + 2) / 5 + dy - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * DAYS_PER_ERA + doe - EPOCH_SHIFT + SERIAL_OFFSET;
        us   = (hr * 3600 + mn * 60 + sc) * US_PER_SECOND + mu;

        r.serial_day = days[SERIAL_W-1:0];
        r.time_us    = us[TIME_W-1:0];
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_serials.size() == 0) begin
                    $error("result transfer with no datetime pending");
                    o_fail_count++;
                end else begin
                    want = expected_serials.pop_front();
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_serial_day !== want.serial_day) begin
                        $error("serial_day mismatch: expected %0d, actual %0d",
                               want.serial_day, i_serial_day);
                        o_fail_count++;
                    end
                    if (i_time_of_day_us !== want.time_us) begin
                        $error("time_of_day_us mismatch: expected %0d, actual %0d",
                               want.time_us, i_time_of_day_us);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                expected_serials.push_back(serial_of_datetime(
                    i_year, i_month, i_day, i_hour, i_twelve_hour_clock,
                    i_after_noon, i_minute, i_second, i_microsecond));
            o_pending = expected_serials.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// top of the testbench for civil_datetime_to_serial_date_unit: clock, reset, datetime
// stimulus, output stall patterns and the verdict
// depends on cdsd_pkg, the unit itself and cdsd_serial_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdsd_pkg::*;

    // output stall behavior, chosen per segment
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_CYCLES = 8;    // pipeline is three stages deep

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [YEAR_W-1:0]           i_year;
    logic [FIELD_W-1:0]          i_month;
    logic [FIELD_W-1:0]          i_day;
    logic [FIELD_W-1:0]          i_hour;
    logic                        i_twelve_hour_clock;
    logic                        i_after_noon;
    logic [FIELD_W-1:0]          i_minute;
    logic [FIELD_W-1:0]          i_second;
    logic [MICRO_W-1:0]          i_microsecond;
    logic                        o_valid;
    logic                        i_stall;
    logic [STATUS_W-1:0]         o_status;
    logic signed [SERIAL_W-1:0]  o_serial_day;
    logic [TIME_W-1:0]           o_time_of_day_us;

    int mismatch_count;
    int results_pending;

    civil_datetime_to_serial_date_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_year              (i_year),
        .i_month             (i_month),
        .i_day               (i_day),
        .i_hour              (i_hour),
        .i_twelve_hour_clock (i_twelve_hour_clock),
        .i_after_noon        (i_after_noon),
        .i_minute            (i_minute),
        .i_second            (i_second),
        .i_microsecond       (i_microsecond),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_serial_day        (o_serial_day),
        .o_time_of_day_us    (o_time_of_day_us)
    );

    // prediction and comparison live in the checker, we only read its counters
    cdsd_serial_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (i_valid),
        .i_req_stall         (o_stall),
        .i_year              (i_year),
        .i_month             (i_month),
        .i_day               (i_day),
        .i_hour              (i_hour),
        .i_twelve_hour_clock (i_twelve_hour_clock),
        .i_after_noon        (i_after_noon),
        .i_minute            (i_minute),
        .i_second            (i_second),
        .i_microsecond       (i_microsecond),
        .i_rsp_valid         (o_valid),
        .i_rsp_stall         (i_stall),
        .i_status            (o_status),
        .i_serial_day        (o_serial_day),
        .i_time_of_day_us    (o_time_of_day_us),
        .o_fail_count        (mismatch_count),
        .o_pending           (results_pending)
    );

    // 12 ns period
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // offer one datetime at the falling edge and hold it until the transfer
    task automatic offer_datetime(
        input logic [YEAR_W-1:0]  year,
        input logic [FIELD_W-1:0] month,
        input logic [FIELD_W-1:0] day,
        input logic [FIELD_W-1:0] hour,
        input logic               twelve,
        input logic               pm,
        input logic [FIELD_W-1:0] minute,
        input logic [FIELD_W-1:0] second,
        input logic [MICRO_W-1:0] micro
    );
        @(negedge i_clk);
        i_valid             <= 1'b1;
        i_year              <= year;
        i_month             <= month;
        i_day               <= day;
        i_hour              <= hour;
        i_twelve_hour_clock <= twelve;
        i_after_noon        <= pm;
        i_minute            <= minute;
        i_second            <= second;
        i_microsecond       <= micro;
        // o_stall is sampled before the edge's register updates land
        do
            @(posedge i_clk);
        while (o_stall);
    endtask

    // mostly well-formed datetimes, some with one bad field, some raw noise
    task automatic offer_random_datetime();
        int                 kind;
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month, day, hour, minute, second;
        logic               twelve, pm;
        logic [MICRO_W-1:0] micro;
        kind   = $urandom_range(0, 99);
        year   = ($urandom_range(0, 9) == 0) ? 14'($urandom_range(0, 16383))
                                             : 14'($urandom_range(0, 9999));
        month  = 7'($urandom_range(1, 12));
        // days past 28 are sometimes beyond the month end, which is wanted
        day    = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(29, 31))
                                             : 7'($urandom_range(1, 28));
        twelve = 1'($urandom_range(0, 1));
        pm     = 1'($urandom_range(0, 1));
        hour   = twelve ? 7'($urandom_range(1, 12)) : 7'($urandom_range(0, 23));
        minute = 7'($urandom_range(0, 59));
        second = 7'($urandom_range(0, 59));
        micro  = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 1048575))
                                             : 20'($urandom_range(0, 999999));
        if (kind < 8)
            month = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(13, 127));
        else if (kind < 14)
            day = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(32, 127));
        else if (kind < 20)
            hour = twelve ? ($urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(13, 127)))
                          : 7'($urandom_range(24, 127));
        else if (kind < 24)
            minute = 7'($urandom_range(60, 127));
        else if (kind < 28)
            second = 7'($urandom_range(60, 127));
        else if (kind < 36) begin
            // every field straight from random bits
            year   = 14'($urandom);
            month  = 7'($urandom);
            day    = 7'($urandom);
            hour   = 7'($urandom);
            minute = 7'($urandom);
            second = 7'($urandom);
            micro  = 20'($urandom);
        end
        offer_datetime(year, month, day, hour, twelve, pm, minute, second, micro);
    endtask

    // sending side: directed corners, then random bursts with gaps
    initial begin
        int sent, burst, gap;
        sent                = 0;
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_year              = '0;
        i_month             = '0;
        i_day               = '0;
        i_hour              = '0;
        i_twelve_hour_clock = 1'b0;
        i_after_noon        = 1'b0;
        i_minute            = '0;
        i_second            = '0;
        i_microsecond       = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // epoch day, unix epoch, earliest and latest four-digit dates
        offer_datetime(1899, 12, 30, 0, 0, 0, 0, 0, 0);
        offer_datetime(1970, 1, 1, 0, 0, 0, 0, 0, 0);
        offer_datetime(0, 1, 1, 0, 0, 0, 0, 0, 0);
        offer_datetime(9999, 12, 31, 23, 0, 0, 59, 59, 999999);
        // leap rule: divisible by 400, by 100 only, by 4, and not at all
        offer_datetime(2000, 2, 29, 12, 0, 0, 30, 30, 500000);
        offer_datetime(1900, 2, 29, 0, 0, 0, 0, 0, 0);
        offer_datetime(2024, 2, 29, 0, 0, 0, 0, 0, 0);
        offer_datetime(2023, 2, 29, 0, 0, 0, 0, 0, 0);
        // bad month, and every field bad at once where month must win
        offer_datetime(2021, 0, 1, 0, 0, 0, 0, 0, 0);
        offer_datetime(2021, 13, 1, 0, 0, 0, 0, 0, 0);
        offer_datetime(16383, 127, 127, 127, 1, 1, 127, 127, 1048575);
        // bad day: zero, past a thirty-day month, all ones
        offer_datetime(2021, 5, 0, 0, 0, 0, 0, 0, 0);
        offer_datetime(2021, 4, 31, 0, 0, 0, 0, 0, 0);
        offer_datetime(2021, 1, 127, 0, 0, 0, 0, 0, 0);
        // hours: 24 in day mode, 0 and 13 on the twelve-hour clock
        offer_datetime(2021, 6, 15, 24, 0, 0, 0, 0, 0);
        offer_datetime(2021, 6, 15, 0, 1, 0, 0, 0, 0);
        offer_datetime(2021, 6, 15, 13, 1, 1, 0, 0, 0);
        // twelve am is midnight, twelve pm is noon, eleven pm, pm ignored in day mode
        offer_datetime(2021, 6, 15, 12, 1, 0, 1, 2, 3);
        offer_datetime(2021, 6, 15, 12, 1, 1, 1, 2, 3);
        offer_datetime(2021, 6, 15, 11, 1, 1, 59, 59, 999999);
        offer_datetime(2021, 6, 15, 7, 0, 1, 0, 0, 0);
        // minute and second out of range
        offer_datetime(2021, 6, 15, 7, 0, 0, 60, 0, 0);
        offer_datetime(2021, 6, 15, 7, 0, 0, 5, 127, 0);
        // microsecond saturation, and a year far past 9999 that wraps the day count
        offer_datetime(2021, 6, 15, 7, 0, 0, 5, 5, 1048575);
        offer_datetime(16383, 12, 31, 23, 0, 0, 59, 59, 1000000);

        // random bursts; a quarter of the bursts run straight into the next one
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 24);
            repeat (burst) begin
                offer_random_datetime();
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then watch a few more cycles for stray transfers
        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("** civil_datetime_to_serial_date_unit: PASSED **");
        else
            $display("** civil_datetime_to_serial_date_unit: FAILED **");
        $finish;
    end

    // receiving side: segments of differing stall patterns, one long hold-off
    initial begin
        stall_mode_t mode;
        int          seg, seg_len, period, k;
        i_stall = 1'b0;
        seg     = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (seg == 4) begin
                // long hold-off while the sender keeps offering, fills the pipeline
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end else begin
                seg_len = $urandom_range(16, 160);
                period  = $urandom_range(2, 7);
                mode    = stall_mode_t'($urandom_range(0, 3));
                for (k = 0; k < seg_len; k++) begin
                    @(negedge i_clk);
                    case (mode)
                        STALL_NONE:     i_stall <= 1'b0;
                        STALL_COIN:     i_stall <= 1'($urandom_range(0, 1));
                        STALL_PERIODIC: i_stall <= ((k % period) == 0);
                        default:        i_stall <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
            seg++;
        end
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("** civil_datetime_to_serial_date_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
src/cdsd_pkg.sv
src/cdsd_check.sv
src/cdsd_calc.sv
src/cdsd_out.sv
src/civil_datetime_to_serial_date_unit.sv
tb/sv/cdsd_serial_checker.sv
tb/sv/tb.sv
